// ===== sv/ramr_pkg.sv =====
// Package with widths, operation codes and shared types of the rational unit.
`default_nettype none
package ramr_pkg;
  localparam int W = 32;
  localparam int DW = 31;
  localparam logic [1:0] OP_RED = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
  } frac_t;
endpackage
`default_nettype wire

// ===== sv/ramr_norm.sv =====
// Iterative fraction normaliser: sign fix, Euclidean gcd and two divisions.
`default_nettype none
module ramr_norm import ramr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] n_in,
  input  wire logic [W-1:0] d_in,
  output logic              done,
  output frac_t             res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam int CW = $clog2(W + 1);

  logic [2:0] st_r, st_nxt;
  logic [W-1:0] mn_r, dd_r, x_r, y_r;
  logic [W-1:0] quo_r, rem_r, dvd_r;
  logic [CW-1:0] cnt_r;
  logic neg_r;
  // Shared restoring divider step: one quotient bit a cycle.
  logic [W:0] trial;
  logic [W-1:0] divisor;
  logic [W-1:0] dn, nn;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (go) st_nxt = S_GCD;
      S_GCD:  if (y_r == '0 && cnt_r == '0) st_nxt = S_DIVN;
      S_DIVN: if (cnt_r == CW'(W)) st_nxt = S_DIVD;
      S_DIVD: if (cnt_r == CW'(W)) st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign divisor = (st_r == S_GCD) ? y_r : x_r;
  assign trial = {rem_r, dvd_r[W-1]} - {1'b0, divisor};
  assign dn = (d_in == '0) ? W'(1) : d_in;
  assign nn = dn[W-1] ? (W'(0) - n_in) : n_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    unique case (st_r)
      S_IDLE: begin
        // Move a negative denominator's sign to the numerator.
        dd_r  <= dn[W-1] ? (W'(0) - dn) : dn;
        neg_r <= nn[W-1];
        mn_r  <= nn[W-1] ? (W'(0) - nn) : nn;
        x_r   <= nn[W-1] ? (W'(0) - nn) : nn;
        y_r   <= dn[W-1] ? (W'(0) - dn) : dn;
        cnt_r <= '0;
      end
      S_GCD: begin
        // Each remainder x mod y is one full divider pass.
        if (cnt_r == '0) begin
          if (y_r != '0) begin
            dvd_r <= x_r;
            rem_r <= '0;
            cnt_r <= CW'(1);
          end else begin
            dvd_r <= mn_r;
            rem_r <= '0;
            cnt_r <= CW'(1);
          end
        end else begin
          dvd_r <= {dvd_r[W-2:0], 1'b0};
          rem_r <= trial[W] ? {rem_r[W-2:0], dvd_r[W-1]} : trial[W-1:0];
          if (cnt_r == CW'(W)) begin
            x_r   <= y_r;
            y_r   <= trial[W] ? {rem_r[W-2:0], dvd_r[W-1]} : trial[W-1:0];
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
      end
      S_DIVN, S_DIVD: begin
        quo_r <= {quo_r[W-2:0], ~trial[W]};
        if (cnt_r == CW'(W)) begin
          cnt_r <= CW'(1);
          dvd_r <= dd_r;
          rem_r <= '0;
          if (st_r == S_DIVN) begin
            mn_r <= {quo_r[W-2:0], ~trial[W]};
          end else begin
            dd_r <= {quo_r[W-2:0], ~trial[W]};
          end
        end else begin
          dvd_r <= {dvd_r[W-2:0], 1'b0};
          rem_r <= trial[W] ? {rem_r[W-2:0], dvd_r[W-1]} : trial[W-1:0];
          cnt_r <= cnt_r + CW'(1);
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  assign done = (st_r == S_DONE);
  assign res.num = neg_r ? (W'(0) - mn_r) : mn_r;
  assign res.den = dd_r;
endmodule
`default_nettype wire

// ===== sv/rational_add_multiply_reduce_unit.sv =====
// Top level of the rational add, multiply, reduce and compare unit.
//  channel | ports                                  | handshake
//  input   | in_req_type in_a_* in_b_*              | start && !busy
//  result  | out_res_num out_res_den out_equal      | out_valid, one cycle
// Each operand and the raw result go through one shared normaliser in turn.
// A normalisation runs its Euclid steps, each a set-up step and a full
// division, followed by two divisions for numerator and denominator.
// A reduce uses one normalisation, a compare two, an add or multiply three.
// Synchronous active-low reset returns the sequencer to idle.
// The receiver cannot stall: the result is shown for one cycle.
`default_nettype none
module rational_add_multiply_reduce_unit import ramr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_req_type,
  input  wire logic [W-1:0]  in_a_num,
  input  wire logic [W-1:0]  in_a_den,
  input  wire logic [W-1:0]  in_b_num,
  input  wire logic [W-1:0]  in_b_den,
  output logic               out_valid,
  output logic [W-1:0]       out_res_num,
  output logic [DW-1:0]      out_res_den,
  output logic               out_equal
);
  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_NA   = 3'd1;
  localparam logic [2:0] T_NB   = 3'd2;
  localparam logic [2:0] T_MULA = 3'd3;
  localparam logic [2:0] T_MULB = 3'd4;
  localparam logic [2:0] T_NR   = 3'd5;
  localparam logic [2:0] T_OUT  = 3'd6;
  localparam logic [2:0] T_MULC = 3'd7;

  logic [2:0] st_r;
  logic [1:0] op_r;
  logic [W-1:0] bn_r, bd_r, rn_r, rd_r, p_r;
  frac_t a_r, fr;
  logic go_r, done;
  logic [W-1:0] nsel, dsel, ma, mb;
  logic [2*W-1:0] prod;
  logic valid_r, eq_r;
  logic [W-1:0] onum_r;
  logic [DW-1:0] oden_r;

  // Single shared multiplier; products wrap to the word width.
  always_comb begin
    ma = a_r.den; mb = bd_r;
    case (st_r)
      T_MULA: begin ma = a_r.num; mb = (op_r == OP_ADD) ? bd_r : bn_r; end
      T_MULB: begin ma = a_r.den; mb = (op_r == OP_ADD) ? bn_r : bd_r; end
      default: begin ma = a_r.den; mb = bd_r; end
    endcase
  end
  assign prod = ma * mb;

  assign nsel = (st_r == T_NB) ? bn_r : rn_r;
  assign dsel = (st_r == T_NB) ? bd_r : rd_r;

  ramr_norm u_norm (
    .clk(clk), .rst_n(rst_n), .go(go_r), .n_in(nsel), .d_in(dsel),
    .done(done), .res(fr)
  );

  // Sequencer over the operand and result normalisations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= T_IDLE;
      go_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      // Normaliser start pulses and the result strobe.
      go_r    <= (st_r == T_IDLE && start) ||
                 (st_r == T_NA && done && op_r != OP_RED) || (st_r == T_MULC);
      valid_r <= (st_r == T_OUT);
      unique case (st_r)
        T_IDLE: if (start) begin
          op_r <= in_req_type; rn_r <= in_a_num; rd_r <= in_a_den;
          bn_r <= in_b_num; bd_r <= in_b_den;
          st_r <= T_NA;
        end
        T_NA: if (done) begin
          a_r <= fr;
          if (op_r == OP_RED) begin
            rn_r <= fr.num; rd_r <= fr.den; st_r <= T_OUT;
          end else begin
            st_r <= T_NB;
          end
        end
        T_NB: if (done) begin
          bn_r <= fr.num; bd_r <= fr.den;
          if (op_r == OP_CMP) st_r <= T_OUT;
          else st_r <= T_MULA;
        end
        T_MULA: begin
          // add: a.num*b.den first; mul: a.num*b.num
          p_r <= prod[W-1:0]; st_r <= T_MULB;
        end
        T_MULB: begin
          // add: plus a.den*b.num
          if (op_r == OP_ADD) p_r <= p_r + prod[W-1:0];
          st_r <= T_MULC;
        end
        T_MULC: begin
          // Both: denominator a.den*b.den.
          rn_r <= p_r; rd_r <= prod[W-1:0]; st_r <= T_NR;
        end
        T_NR: if (done) begin
          rn_r <= fr.num; rd_r <= fr.den; st_r <= T_OUT;
        end
        T_OUT: begin
          st_r <= T_IDLE;
          if (op_r == OP_CMP) begin
            onum_r <= '0; oden_r <= '0;
            eq_r <= (a_r.num == bn_r) && (a_r.den == bd_r);
          end else begin
            onum_r <= rn_r;
            oden_r <= rd_r[W-1] ? {DW{1'b1}} : rd_r[DW-1:0];
            eq_r <= 1'b0;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign busy        = (st_r != T_IDLE);
  assign out_valid   = valid_r;
  assign out_res_num = onum_r;
  assign out_res_den = oden_r;
  assign out_equal   = eq_r;
endmodule
`default_nettype wire
